// ===== rtl/gbalu_pkg.sv =====
`default_nettype none

package gbalu_pkg;

    // Operation codes carried in the func field.
    localparam logic [4:0] F_ADD   = 5'd0;
    localparam logic [4:0] F_ADC   = 5'd1;
    localparam logic [4:0] F_SUB   = 5'd2;
    localparam logic [4:0] F_SBC   = 5'd3;
    localparam logic [4:0] F_AND   = 5'd4;
    localparam logic [4:0] F_XOR   = 5'd5;
    localparam logic [4:0] F_OR    = 5'd6;
    localparam logic [4:0] F_CP    = 5'd7;
    localparam logic [4:0] F_INC   = 5'd8;
    localparam logic [4:0] F_DEC   = 5'd9;
    localparam logic [4:0] F_RLC   = 5'd10;
    localparam logic [4:0] F_RRC   = 5'd11;
    localparam logic [4:0] F_RL    = 5'd12;
    localparam logic [4:0] F_RR    = 5'd13;
    localparam logic [4:0] F_SLA   = 5'd14;
    localparam logic [4:0] F_SRA   = 5'd15;
    localparam logic [4:0] F_SWAP  = 5'd16;
    localparam logic [4:0] F_SRL   = 5'd17;
    localparam logic [4:0] F_BIT   = 5'd18;
    localparam logic [4:0] F_RES   = 5'd19;
    localparam logic [4:0] F_SET   = 5'd20;
    localparam logic [4:0] F_DAA   = 5'd21;
    localparam logic [4:0] F_CPL   = 5'd22;
    localparam logic [4:0] F_SCF   = 5'd23;
    localparam logic [4:0] F_CCF   = 5'd24;
    localparam logic [4:0] F_RLCA  = 5'd25;
    localparam logic [4:0] F_RRCA  = 5'd26;
    localparam logic [4:0] F_RLA   = 5'd27;
    localparam logic [4:0] F_RRA   = 5'd28;
    localparam logic [4:0] F_ADD16 = 5'd29;
    localparam logic [4:0] F_ADDSP = 5'd30;

    // Shift and rotate kinds, shared by the prefixed and accumulator forms.
    localparam logic [2:0] SH_RLC  = 3'd0;
    localparam logic [2:0] SH_RRC  = 3'd1;
    localparam logic [2:0] SH_RL   = 3'd2;
    localparam logic [2:0] SH_RR   = 3'd3;
    localparam logic [2:0] SH_SLA  = 3'd4;
    localparam logic [2:0] SH_SRA  = 3'd5;
    localparam logic [2:0] SH_SWAP = 3'd6;
    localparam logic [2:0] SH_SRL  = 3'd7;

    // Decimal adjust constants.
    localparam logic [7:0] DAA_LO_FIX = 8'h06;
    localparam logic [7:0] DAA_HI_FIX = 8'h60;
    localparam logic [7:0] DAA_MAX    = 8'h99;
    localparam logic [3:0] DAA_DIGIT  = 4'd9;

    typedef struct packed {
        logic [4:0]  func;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic        zero_in;
        logic        subtract_in;
        logic        half_carry_in;
        logic        carry_in;
    } t_alu_in;

    typedef struct packed {
        logic [15:0] result;
        logic        zero_out;
        logic        subtract_out;
        logic        half_carry_out;
        logic        carry_out;
    } t_alu_out;

endpackage

`default_nettype wire

// ===== rtl/gbalu_stage.sv =====
`default_nettype none

module gbalu_stage #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic [W-1:0] i_data,
    output logic              o_stall,
    output logic              o_valid,
    output logic [W-1:0]      o_data,
    input  wire logic         i_stall
);

    logic         r_valid;
    logic [W-1:0] r_data;
    logic         n_valid;

    // The stage only holds when it has a beat that the next side refuses.
    assign o_stall = r_valid && i_stall;
    assign n_valid = o_stall ? r_valid : i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/gbalu_core.sv =====
`default_nettype none

module gbalu_core
    import gbalu_pkg::*;
(
    input  wire t_alu_in  i_op,
    output t_alu_out o_res
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic        ci;
    logic [8:0]  sum9;
    logic [4:0]  sum5;
    logic [8:0]  dif9;
    logic [4:0]  dif5;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [7:0]  sv;
    logic [2:0]  sk;
    logic [4:0]  sk_wide;
    logic [7:0]  sh_r;
    logic        sh_c;
    logic [7:0]  mask;
    logic [7:0]  daa_adj;
    logic        daa_c;
    logic [7:0]  daa_r;
    logic [16:0] s17;
    logic [12:0] s13;
    logic [15:0] sp_r;
    logic [4:0]  sp5;
    logic [8:0]  sp9;
    logic [7:0]  r8;

    assign a = i_op.operand_a[7:0];
    assign b = i_op.operand_b[7:0];
    assign ci = ((i_op.func == F_ADC) || (i_op.func == F_SBC)) ? i_op.carry_in : 1'b0;

    assign sum9 = {1'b0, a} + {1'b0, b} + {8'd0, ci};
    assign sum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
    assign dif9 = {1'b0, a} - {1'b0, b} - {8'd0, ci};
    assign dif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};
    assign inc8 = b + 8'd1;
    assign dec8 = b - 8'd1;
    assign mask = 8'd1 << i_op.bit_index;

    // Accumulator rotates reuse the prefixed shifter on the accumulator.
    assign sv      = (i_op.func >= F_RLCA) ? a : b;
    assign sk_wide = (i_op.func >= F_RLCA) ? (i_op.func - F_RLCA) : (i_op.func - F_RLC);
    assign sk      = sk_wide[2:0];

    always_comb begin
        sh_c = sv[0];
        sh_r = {1'b0, sv[7:1]};
        case (sk)
            SH_RLC:  begin sh_c = sv[7]; sh_r = {sv[6:0], sv[7]}; end
            SH_RRC:  begin sh_c = sv[0]; sh_r = {sv[0], sv[7:1]}; end
            SH_RL:   begin sh_c = sv[7]; sh_r = {sv[6:0], i_op.carry_in}; end
            SH_RR:   begin sh_c = sv[0]; sh_r = {i_op.carry_in, sv[7:1]}; end
            SH_SLA:  begin sh_c = sv[7]; sh_r = {sv[6:0], 1'b0}; end
            SH_SRA:  begin sh_c = sv[0]; sh_r = {sv[7], sv[7:1]}; end
            SH_SWAP: begin sh_c = 1'b0;  sh_r = {sv[3:0], sv[7:4]}; end
            default: begin sh_c = sv[0]; sh_r = {1'b0, sv[7:1]}; end
        endcase
    end

    // Decimal adjust after an add or a subtract, steered by N, H and C.
    always_comb begin
        daa_adj = 8'd0;
        daa_c   = i_op.carry_in;
        if (i_op.subtract_in) begin
            if (i_op.half_carry_in) daa_adj = daa_adj | DAA_LO_FIX;
            if (i_op.carry_in)      daa_adj = daa_adj | DAA_HI_FIX;
            daa_r = a - daa_adj;
        end else begin
            if (i_op.half_carry_in || (a[3:0] > DAA_DIGIT)) daa_adj = daa_adj | DAA_LO_FIX;
            if (i_op.carry_in || (a > DAA_MAX)) begin
                daa_adj = daa_adj | DAA_HI_FIX;
                daa_c   = 1'b1;
            end
            daa_r = a + daa_adj;
        end
    end

    assign s17  = {1'b0, i_op.operand_a} + {1'b0, i_op.operand_b};
    assign s13  = {1'b0, i_op.operand_a[11:0]} + {1'b0, i_op.operand_b[11:0]};
    assign sp_r = i_op.operand_a + {{8{b[7]}}, b};
    assign sp5  = {1'b0, i_op.operand_a[3:0]} + {1'b0, b[3:0]};
    assign sp9  = {1'b0, i_op.operand_a[7:0]} + {1'b0, b};

    always_comb begin
        o_res.result         = i_op.operand_a;
        o_res.zero_out       = i_op.zero_in;
        o_res.subtract_out   = i_op.subtract_in;
        o_res.half_carry_out = i_op.half_carry_in;
        o_res.carry_out      = i_op.carry_in;
        r8 = 8'd0;
        case (i_op.func)
            F_ADD, F_ADC: begin
                r8 = sum9[7:0];
                o_res.result         = {8'd0, r8};
                o_res.zero_out       = (r8 == 8'd0);
                o_res.subtract_out   = 1'b0;
                o_res.half_carry_out = sum5[4];
                o_res.carry_out      = sum9[8];
            end
            F_SUB, F_SBC, F_CP: begin
                r8 = dif9[7:0];
                o_res.result         = (i_op.func == F_CP) ? i_op.operand_a : {8'd0, r8};
                o_res.zero_out       = (r8 == 8'd0);
                o_res.subtract_out   = 1'b1;
                o_res.half_carry_out = dif5[4];
                o_res.carry_out      = dif9[8];
            end
            F_AND, F_XOR, F_OR: begin
                if (i_op.func == F_AND) r8 = a & b;
                else if (i_op.func == F_XOR) r8 = a ^ b;
                else r8 = a | b;
                o_res.result         = {8'd0, r8};
                o_res.zero_out       = (r8 == 8'd0);
                o_res.subtract_out   = 1'b0;
                o_res.half_carry_out = (i_op.func == F_AND);
                o_res.carry_out      = 1'b0;
            end
            F_INC: begin
                o_res.result         = {8'd0, inc8};
                o_res.zero_out       = (inc8 == 8'd0);
                o_res.subtract_out   = 1'b0;
                o_res.half_carry_out = (inc8[3:0] == 4'h0);
            end
            F_DEC: begin
                o_res.result         = {8'd0, dec8};
                o_res.zero_out       = (dec8 == 8'd0);
                o_res.subtract_out   = 1'b1;
                o_res.half_carry_out = (dec8[3:0] == 4'hF);
            end
            F_RLC, F_RRC, F_RL, F_RR, F_SLA, F_SRA, F_SWAP, F_SRL,
            F_RLCA, F_RRCA, F_RLA, F_RRA: begin
                o_res.result         = {8'd0, sh_r};
                o_res.zero_out       = (i_op.func >= F_RLCA) ? 1'b0 : (sh_r == 8'd0);
                o_res.subtract_out   = 1'b0;
                o_res.half_carry_out = 1'b0;
                o_res.carry_out      = sh_c;
            end
            F_BIT: begin
                o_res.result         = i_op.operand_b;
                o_res.zero_out       = ~b[i_op.bit_index];
                o_res.subtract_out   = 1'b0;
                o_res.half_carry_out = 1'b1;
            end
            F_RES: o_res.result = {8'd0, b & ~mask};
            F_SET: o_res.result = {8'd0, b | mask};
            F_DAA: begin
                o_res.result         = {8'd0, daa_r};
                o_res.zero_out       = (daa_r == 8'd0);
                o_res.half_carry_out = 1'b0;
                o_res.carry_out      = daa_c;
            end
            F_CPL: begin
                o_res.result         = {8'd0, ~a};
                o_res.subtract_out   = 1'b1;
                o_res.half_carry_out = 1'b1;
            end
            F_SCF: begin
                o_res.subtract_out   = 1'b0;
                o_res.half_carry_out = 1'b0;
                o_res.carry_out      = 1'b1;
            end
            F_CCF: begin
                o_res.subtract_out   = 1'b0;
                o_res.half_carry_out = 1'b0;
                o_res.carry_out      = ~i_op.carry_in;
            end
            F_ADD16: begin
                o_res.result         = s17[15:0];
                o_res.subtract_out   = 1'b0;
                o_res.half_carry_out = s13[12];
                o_res.carry_out      = s17[16];
            end
            F_ADDSP: begin
                o_res.result         = sp_r;
                o_res.zero_out       = 1'b0;
                o_res.subtract_out   = 1'b0;
                o_res.half_carry_out = sp5[4];
                o_res.carry_out      = sp9[8];
            end
            default: begin
                o_res.result = i_op.operand_a;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/cpu_alu_with_flags.sv =====
// An accepted beat is registered in the input stage, passes through the flag ALU
// and is captured in the result register, from which its result beat is offered.
// Throughput: one beat per cycle unless the output stalls; the input register feeds
// the flag ALU, whose result is captured in the output register.
// A result that waits on a stalled output holds the pipe; the input stalls only
// when both registers are full and the output is stalled. Reset is synchronous
// and active low; it empties both stages.
`default_nettype none

module cpu_alu_with_flags
    import gbalu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_alu_in i_in,
    output logic         o_in_stall,
    output logic         o_out_valid,
    output t_alu_out     o_out,
    input  wire logic    i_out_stall
);

    logic     w_mid_valid;
    t_alu_in  w_mid_data;
    logic     w_mid_stall;
    t_alu_out w_core_res;

    // First stage: operation and operands are registered as they arrive.
    gbalu_stage #(
        .W($bits(t_alu_in))
    ) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in),
        .o_stall (o_in_stall),
        .o_valid (w_mid_valid),
        .o_data  (w_mid_data),
        .i_stall (w_mid_stall)
    );

    // The whole operation, flags included, is one short combinational pass.
    gbalu_core u_core (
        .i_op  (w_mid_data),
        .o_res (w_core_res)
    );

    // Second stage: the result register. While its beat is refused, the beat
    // behind it waits in the first stage, and the input stalls only once that
    // stage is full as well.
    gbalu_stage #(
        .W($bits(t_alu_out))
    ) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mid_valid),
        .i_data  (w_core_res),
        .o_stall (w_mid_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out),
        .i_stall (i_out_stall)
    );

    // A refused result beat stays offered and does not change.
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid);
    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out));
    // Back pressure on the input only ever comes from the output side.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> i_out_stall);
    // Reset leaves the pipe empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall));

endmodule

`default_nettype wire

// ===== tb/tb_cpu_alu_with_flags.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the flag ALU. The ALU is purely combinational behind
// a short valid/stall pipe, so every accepted input beat yields exactly one
// output beat, in order. The bench keeps its own model of the ALU, computes the
// expected beat when the input beat is accepted, and compares it with the next
// beat that leaves the block.
module tb_cpu_alu_with_flags
    import gbalu_pkg::*;
();

    // The one func code that the package leaves without a name.
    localparam logic [4:0] F_UNUSED = 5'd31;

    // Flag nibble order used by the directed beats: {Z, N, H, C}.
    localparam logic [3:0] FL_NONE = 4'b0000;
    localparam logic [3:0] FL_C    = 4'b0001;
    localparam logic [3:0] FL_H    = 4'b0010;
    localparam logic [3:0] FL_Z    = 4'b1000;
    localparam logic [3:0] FL_NHC  = 4'b0111;
    localparam logic [3:0] FL_ALL  = 4'b1111;

    localparam int HOLD_CYCLES = 64;

    logic     i_clk      = 1'b0;
    logic     i_rst_n    = 1'b0;
    logic     i_in_valid = 1'b0;
    t_alu_in  i_in       = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_alu_out o_out;

    // Beats waiting to be offered, and results the ALU still owes us.
    t_alu_in  op_backlog[$];
    t_alu_out owed_results[$];

    int       send_idle_pct = 38;
    int       recv_idle_pct = 38;
    int       hold_req = 0;
    int       hold_done = 0;
    int       hold_left = 0;
    int       mismatch_cnt = 0;
    t_alu_out want;

    cpu_alu_with_flags u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_out_stall(i_out_stall)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bit-exact model of the ALU. Eight-bit operations work on the low bytes and return
    // a zero high byte, except CP and BIT; untouched flags pass straight through.
    function automatic t_alu_out alu_model(input t_alu_in x);
        t_alu_out   y;
        logic [7:0] a, b, v, r, adj;
        logic [8:0] sum9;
        logic [16:0] sum17;
        logic [2:0] kind;
        logic       z, n, h, c, cin, nc, is_acc;
        a = x.operand_a[7:0];
        b = x.operand_b[7:0];
        z = x.zero_in;
        n = x.subtract_in;
        h = x.half_carry_in;
        c = x.carry_in;
        y.result = x.operand_a;
        case (x.func)
            F_ADD, F_ADC: begin
                cin = (x.func == F_ADC) ? c : 1'b0;
                sum9 = {1'b0, a} + {1'b0, b} + cin;
                y.result = {8'h00, sum9[7:0]};
                h = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + cin) > 5'h0F;
                c = sum9[8];
                n = 1'b0;
                z = (sum9[7:0] == 8'h00);
            end
            F_SUB, F_SBC, F_CP: begin
                cin = (x.func == F_SBC) ? c : 1'b0;
                sum9 = {1'b0, a} - {1'b0, b} - cin;
                h = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + cin);
                c = {1'b0, a} < ({1'b0, b} + cin);
                n = 1'b1;
                z = (sum9[7:0] == 8'h00);
                // Compare keeps the whole accumulator word.
                y.result = (x.func == F_CP) ? x.operand_a : {8'h00, sum9[7:0]};
            end
            F_AND: begin
                r = a & b;
                y.result = {8'h00, r};
                z = (r == 8'h00);
                n = 1'b0;
                h = 1'b1;
                c = 1'b0;
            end
            F_XOR, F_OR: begin
                r = (x.func == F_XOR) ? (a ^ b) : (a | b);
                y.result = {8'h00, r};
                z = (r == 8'h00);
                n = 1'b0;
                h = 1'b0;
                c = 1'b0;
            end
            F_INC: begin
                r = b + 8'h01;
                y.result = {8'h00, r};
                z = (r == 8'h00);
                n = 1'b0;
                h = (r[3:0] == 4'h0);
            end
            F_DEC: begin
                r = b - 8'h01;
                y.result = {8'h00, r};
                z = (r == 8'h00);
                n = 1'b1;
                h = (r[3:0] == 4'hF);
            end
            F_RLC, F_RRC, F_RL, F_RR, F_SLA, F_SRA, F_SWAP, F_SRL,
            F_RLCA, F_RRCA, F_RLA, F_RRA: begin
                // Prefixed shifts act on operand_b, the accumulator forms on
                // operand_a; both share the same kind encoding.
                is_acc = (x.func >= F_RLCA);
                v = is_acc ? a : b;
                kind = is_acc ? 3'(x.func - F_RLCA) : 3'(x.func - F_RLC);
                case (kind)
                    SH_RLC:  begin nc = v[7]; r = {v[6:0], v[7]}; end
                    SH_RRC:  begin nc = v[0]; r = {v[0], v[7:1]}; end
                    SH_RL:   begin nc = v[7]; r = {v[6:0], c}; end
                    SH_RR:   begin nc = v[0]; r = {c, v[7:1]}; end
                    SH_SLA:  begin nc = v[7]; r = {v[6:0], 1'b0}; end
                    SH_SRA:  begin nc = v[0]; r = {v[7], v[7:1]}; end
                    SH_SWAP: begin nc = 1'b0; r = {v[3:0], v[7:4]}; end
                    default: begin nc = v[0]; r = {1'b0, v[7:1]}; end
                endcase
                y.result = {8'h00, r};
                c = nc;
                n = 1'b0;
                h = 1'b0;
                // Accumulator rotates always clear Z.
                z = is_acc ? 1'b0 : (r == 8'h00);
            end
            F_BIT: begin
                z = ~b[x.bit_index];
                n = 1'b0;
                h = 1'b1;
                y.result = x.operand_b;
            end
            F_RES: y.result = {8'h00, b & ~(8'h01 << x.bit_index)};
            F_SET: y.result = {8'h00, b | (8'h01 << x.bit_index)};
            F_DAA: begin
                adj = 8'h00;
                nc = c;
                if (n) begin
                    if (h) adj = adj | DAA_LO_FIX;
                    if (c) adj = adj | DAA_HI_FIX;
                    r = a - adj;
                end else begin
                    if (h || a[3:0] > DAA_DIGIT) adj = adj | DAA_LO_FIX;
                    if (c || a > DAA_MAX) begin
                        adj = adj | DAA_HI_FIX;
                        nc = 1'b1;
                    end
                    r = a + adj;
                end
                y.result = {8'h00, r};
                z = (r == 8'h00);
                h = 1'b0;
                c = nc;
            end
            F_CPL: begin
                y.result = {8'h00, ~a};
                n = 1'b1;
                h = 1'b1;
            end
            F_SCF: begin
                n = 1'b0;
                h = 1'b0;
                c = 1'b1;
            end
            F_CCF: begin
                n = 1'b0;
                h = 1'b0;
                c = ~c;
            end
            F_ADD16: begin
                sum17 = {1'b0, x.operand_a} + {1'b0, x.operand_b};
                y.result = sum17[15:0];
                n = 1'b0;
                h = ({1'b0, x.operand_a[11:0]} + {1'b0, x.operand_b[11:0]}) > 13'h0FFF;
                c = sum17[16];
            end
            F_ADDSP: begin
                // Signed offset on the word, but H and C come from the
                // unsigned add of the low bytes.
                y.result = x.operand_a + {{8{b[7]}}, b};
                z = 1'b0;
                n = 1'b0;
                h = ({1'b0, x.operand_a[3:0]} + {1'b0, b[3:0]}) > 5'h0F;
                c = ({1'b0, x.operand_a[7:0]} + {1'b0, b}) > 9'h0FF;
            end
            default: ;
        endcase
        y.zero_out = z;
        y.subtract_out = n;
        y.half_carry_out = h;
        y.carry_out = c;
        return y;
    endfunction

    function automatic t_alu_in alu_op(input logic [4:0] func, input logic [15:0] a,
                                       input logic [15:0] b, input logic [2:0] bi,
                                       input logic [3:0] flags);
        t_alu_in x;
        x.func = func;
        x.operand_a = a;
        x.operand_b = b;
        x.bit_index = bi;
        {x.zero_in, x.subtract_in, x.half_carry_in, x.carry_in} = flags;
        return x;
    endfunction

    // Operand words lean toward carry and BCD boundaries a quarter of the time.
    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        w = 16'($urandom);
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(7))
                0: w = 16'h0000;
                1: w = 16'hFFFF;
                2: w = 16'h00FF;
                3: w = 16'h0FFF;
                4: w = {w[15:8], 8'h80};
                5: w = {w[15:8], 8'h0F};
                6: w = {w[15:8], 8'h99};
                default: w = {w[15:8], 4'($urandom_range(9)), 4'($urandom_range(9))};
            endcase
        end
        return w;
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            op_backlog.push_back(alu_op(5'($urandom_range(31)), pick_word(), pick_word(),
                                        3'($urandom_range(7)), 4'($urandom_range(15))));
    endtask

    // The sender holds back here until every beat is out and every result in.
    task automatic wait_drained();
        while (op_backlog.size() != 0 || i_in_valid || owed_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Driver. A new beat is picked only when the current one has been accepted
    // or none is up, so valid never looks at stall and a stalled beat holds.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid)
                owed_results.push_back(alu_model(i_in));
            if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in <= op_backlog.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall. A requested hold keeps stall high until its hold counter runs
    // out, so the pipe fills and pushes back on the input side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor. Every result beat is matched against the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result beat: result=%h z=%b n=%b h=%b c=%b",
                             o_out.result, o_out.zero_out, o_out.subtract_out,
                             o_out.half_carry_out, o_out.carry_out);
            end else begin
                want = owed_results.pop_front();
                if (o_out.result !== want.result || o_out.zero_out !== want.zero_out ||
                    o_out.subtract_out !== want.subtract_out ||
                    o_out.half_carry_out !== want.half_carry_out ||
                    o_out.carry_out !== want.carry_out) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: want %h znhc=%b%b%b%b, got %h znhc=%b%b%b%b",
                                 want.result, want.zero_out, want.subtract_out,
                                 want.half_carry_out, want.carry_out,
                                 o_out.result, o_out.zero_out, o_out.subtract_out,
                                 o_out.half_carry_out, o_out.carry_out);
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats: carry and half-carry edges, borrow, compare keeping
        // the full word, zero results, bit ops at both ends, both decimal
        // adjust directions, accumulator rotates clearing Z, the 16-bit add
        // with its bit 11 carry, stack plus a negative offset, and the unused code.
        op_backlog.push_back(alu_op(F_ADD,   16'hA5FF, 16'h3C01, 3'd0, FL_NONE));
        op_backlog.push_back(alu_op(F_ADC,   16'h000F, 16'h0000, 3'd0, FL_C));
        op_backlog.push_back(alu_op(F_ADC,   16'hFFFF, 16'hFFFF, 3'd0, FL_C));
        op_backlog.push_back(alu_op(F_SUB,   16'h0000, 16'h0001, 3'd0, FL_NONE));
        op_backlog.push_back(alu_op(F_SBC,   16'h0010, 16'h000F, 3'd0, FL_C));
        op_backlog.push_back(alu_op(F_CP,    16'hAB3C, 16'h003C, 3'd0, FL_NONE));
        op_backlog.push_back(alu_op(F_AND,   16'h00F0, 16'h000F, 3'd0, FL_ALL));
        op_backlog.push_back(alu_op(F_XOR,   16'h005A, 16'h005A, 3'd0, FL_ALL));
        op_backlog.push_back(alu_op(F_OR,    16'h0000, 16'h0000, 3'd0, FL_NONE));
        op_backlog.push_back(alu_op(F_INC,   16'h0000, 16'hFFFF, 3'd0, FL_C));
        op_backlog.push_back(alu_op(F_DEC,   16'h0000, 16'h0000, 3'd0, FL_NONE));
        op_backlog.push_back(alu_op(F_DEC,   16'h0000, 16'h0010, 3'd0, FL_C));
        op_backlog.push_back(alu_op(F_RL,    16'h0000, 16'h0080, 3'd0, FL_C));
        op_backlog.push_back(alu_op(F_SRA,   16'h0000, 16'h0081, 3'd0, FL_NONE));
        op_backlog.push_back(alu_op(F_SWAP,  16'h0000, 16'h00F0, 3'd0, FL_ALL));
        op_backlog.push_back(alu_op(F_BIT,   16'h0000, 16'hFF7F, 3'd7, FL_C));
        op_backlog.push_back(alu_op(F_RES,   16'h0000, 16'hFFFF, 3'd0, FL_NHC));
        op_backlog.push_back(alu_op(F_SET,   16'h0000, 16'h0000, 3'd7, FL_Z));
        op_backlog.push_back(alu_op(F_DAA,   16'h009A, 16'h0000, 3'd0, FL_NONE));
        op_backlog.push_back(alu_op(F_DAA,   16'h0000, 16'h0000, 3'd0, FL_NHC));
        op_backlog.push_back(alu_op(F_CPL,   16'h1200, 16'h0000, 3'd0, FL_NONE));
        op_backlog.push_back(alu_op(F_CCF,   16'h4321, 16'h0000, 3'd0, FL_ALL));
        op_backlog.push_back(alu_op(F_RLCA,  16'h0080, 16'h0000, 3'd0, FL_Z));
        op_backlog.push_back(alu_op(F_ADD16, 16'hFFFF, 16'h0001, 3'd0, FL_NONE));
        op_backlog.push_back(alu_op(F_ADD16, 16'h0FFF, 16'h0001, 3'd0, FL_ALL));
        op_backlog.push_back(alu_op(F_ADDSP, 16'h0000, 16'h00FF, 3'd0, FL_ALL));
        op_backlog.push_back(alu_op(F_UNUSED, 16'hBEEF, 16'h1234, 3'd5, FL_ALL));
        wait_drained();

        // Random beats with idling on both sides.
        queue_random(800);
        wait_drained();

        // A long stretch with no idling anywhere: back-to-back beats.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(400);
        wait_drained();

        // The receiver holds off while the sender keeps offering, so the pipe
        // fills and the input stalls; afterwards the sender waits for the drain.
        recv_idle_pct = 38;
        hold_req = hold_req + 1;
        queue_random(60);
        wait_drained();

        send_idle_pct = 38;
        queue_random(700);
        wait_drained();

        // Leave room for any stray beat still inside the pipe.
        repeat (8) @(negedge i_clk);
        if (mismatch_cnt == 0 && owed_results.size() == 0) begin
            $display("cpu_alu_with_flags test passed");
        end else begin
            $display("cpu_alu_with_flags test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("cpu_alu_with_flags test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gbalu_pkg.sv
rtl/gbalu_stage.sv
rtl/gbalu_core.sv
rtl/cpu_alu_with_flags.sv
tb/tb_cpu_alu_with_flags.sv
